[src/wpdr_pkg.sv]
// ----------------------------------------------------------------------------
// wpdr_pkg
// Shared types, register codes and constants for the windowed PID regulator.
// ----------------------------------------------------------------------------
package wpdr_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_GAIN_P        = 3'd0;
  localparam logic [2:0] REG_GAIN_I        = 3'd1;
  localparam logic [2:0] REG_GAIN_D        = 3'd2;
  localparam logic [2:0] REG_WINDOW        = 3'd3;
  localparam logic [2:0] REG_OUTPUT_LIMIT  = 3'd4;
  localparam logic [2:0] REG_STARTUP_LIMIT = 3'd5;
  localparam logic [2:0] REG_STARTUP_TICKS = 3'd6;
  localparam logic [2:0] REG_TURN_MODE     = 3'd7;

  // Register reset values
  localparam logic [15:0] GAIN_P_RST        = 16'd179;
  localparam logic [15:0] GAIN_I_RST        = 16'd38;
  localparam logic [15:0] GAIN_D_RST        = 16'd320;
  localparam logic [15:0] WINDOW_RST        = 16'd100;
  localparam logic [6:0]  OUTPUT_LIMIT_RST  = 7'd100;
  localparam logic [6:0]  STARTUP_LIMIT_RST = 7'd50;
  localparam logic [2:0]  STARTUP_TICKS_RST = 3'd4;

  // Tick counter saturates here
  localparam logic [2:0] TICK_MAX = 3'd7;

  // Motor scale 19/20: multiply by 19, then by 3277/65536 in place of /20
  localparam logic [11:0] MOTOR_NUM   = 12'd19;
  localparam logic [23:0] RECIP_20    = 24'd3277;
  localparam int          RECIP_SHIFT = 16;

  // Program steps
  localparam int          STEP_W      = 3;
  localparam logic [2:0]  STEP_WAIT   = 3'd0;
  localparam logic [2:0]  STEP_ERROR  = 3'd1;
  localparam logic [2:0]  STEP_MUL_P  = 3'd2;
  localparam logic [2:0]  STEP_MUL_D  = 3'd3;
  localparam logic [2:0]  STEP_MUL_I  = 3'd4;
  localparam logic [2:0]  STEP_INTEG  = 3'd5;
  localparam logic [2:0]  STEP_SUM    = 3'd6;
  localparam logic [2:0]  STEP_EMIT   = 3'd7;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_P    = 2'd1,
    MUL_D    = 2'd2,
    MUL_I    = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD     = 2'd0,
    ACC_LOAD     = 2'd1,
    ACC_ADD_PROD = 2'd2,
    ACC_ADD_INT  = 2'd3
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_NO_INPUT = 2'd1,
    COND_OUT_BUSY = 2'd2,
    COND_ALWAYS   = 2'd3
  } cond_t;

  // One control word of the program
  typedef struct packed {
    mul_sel_t          mul;
    acc_op_t           acc;
    logic              load_in;
    logic              latch_err;
    logic              upd_int;
    logic              emit;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Handshake status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } seq_status_t;

  // Configuration registers
  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] integral_window;
    logic [6:0]  output_limit;
    logic [6:0]  startup_limit;
    logic [2:0]  startup_ticks;
    logic        turn_mode;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic signed [7:0]  drive_power;
    logic signed [7:0]  motor_command;
    logic signed [21:0] error_value;
  } result_t;

  // Magnitude times 19/20, truncated
  function automatic logic [6:0] motor_scale(input logic [6:0] mag);
    logic [11:0] scaled;
    logic [23:0] prod;
    scaled = 12'(mag) * MOTOR_NUM;
    prod   = 24'(scaled) * RECIP_20;
    return 7'(prod >> RECIP_SHIFT);
  endfunction

endpackage

[src/wpdr_sequencer.sv]
// ----------------------------------------------------------------------------
// wpdr_sequencer
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module wpdr_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  wpdr_pkg::seq_status_t  status,
  output wpdr_pkg::ctrl_word_t   ctrl,
  output logic                   ready
);

  logic [wpdr_pkg::STEP_W-1:0] pc;
  logic [wpdr_pkg::STEP_W-1:0] pc_next;
  wpdr_pkg::ctrl_word_t        word;
  logic                        jump;

  // Control store
  function automatic wpdr_pkg::ctrl_word_t program_word(input logic [wpdr_pkg::STEP_W-1:0] step);
    wpdr_pkg::ctrl_word_t w;
    w = '{mul: wpdr_pkg::MUL_NONE, acc: wpdr_pkg::ACC_HOLD, load_in: 1'b0,
          latch_err: 1'b0, upd_int: 1'b0, emit: 1'b0,
          cond: wpdr_pkg::COND_NEVER, target: wpdr_pkg::STEP_WAIT};
    unique case (step)
      wpdr_pkg::STEP_WAIT: begin
        w.load_in = 1'b1;
        w.cond    = wpdr_pkg::COND_NO_INPUT;
        w.target  = wpdr_pkg::STEP_WAIT;
      end
      wpdr_pkg::STEP_ERROR: begin
        w.latch_err = 1'b1;
      end
      wpdr_pkg::STEP_MUL_P: begin
        w.mul = wpdr_pkg::MUL_P;
      end
      wpdr_pkg::STEP_MUL_D: begin
        w.mul = wpdr_pkg::MUL_D;
        w.acc = wpdr_pkg::ACC_LOAD;
      end
      wpdr_pkg::STEP_MUL_I: begin
        w.mul = wpdr_pkg::MUL_I;
        w.acc = wpdr_pkg::ACC_ADD_PROD;
      end
      wpdr_pkg::STEP_INTEG: begin
        w.upd_int = 1'b1;
      end
      wpdr_pkg::STEP_SUM: begin
        w.acc = wpdr_pkg::ACC_ADD_INT;
      end
      wpdr_pkg::STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = wpdr_pkg::COND_OUT_BUSY;
        w.target = wpdr_pkg::STEP_EMIT;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  assign word  = program_word(pc);
  assign ready = (pc == wpdr_pkg::STEP_WAIT);

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      wpdr_pkg::COND_NO_INPUT: jump = !status.in_valid;
      wpdr_pkg::COND_OUT_BUSY: jump = status.out_busy;
      wpdr_pkg::COND_ALWAYS:   jump = 1'b1;
      default:                 jump = 1'b0;
    endcase
    pc_next = jump ? word.target : pc + 1'b1;
  end

  // Gate the side effects of waiting steps
  always_comb begin
    ctrl         = word;
    ctrl.load_in = word.load_in && status.in_valid;
    ctrl.emit    = word.emit && !status.out_busy;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= wpdr_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[src/wpdr_datapath.sv]
// ----------------------------------------------------------------------------
// wpdr_datapath
// Error, shared gain multiplier, accumulator, integral and output clamp.
// ----------------------------------------------------------------------------
module wpdr_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  wpdr_pkg::ctrl_word_t  ctrl,
  input  wpdr_pkg::cfg_t        cfg,
  input  logic                  restart,
  input  logic signed [20:0]    target,
  input  logic signed [20:0]    encoder_count,
  input  logic signed [15:0]    gyro_angle,
  output wpdr_pkg::result_t     result
);

  logic signed [20:0] tgt_q;
  logic signed [20:0] enc_q;
  logic signed [15:0] ang_q;
  logic signed [15:0] start_angle;
  logic signed [21:0] err_q;
  logic signed [21:0] prev_err;
  logic signed [39:0] prod;
  logic signed [41:0] acc;
  logic signed [31:0] integral;
  logic [2:0]         tick;

  logic signed [21:0] err_drive;
  logic signed [21:0] err_turn;
  logic signed [22:0] err_wide;
  logic signed [22:0] err_diff;
  logic signed [22:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [39:0] mul_out;
  logic signed [40:0] int_sum;
  logic signed [31:0] int_sat;
  logic signed [22:0] win_lim;
  logic               in_window;
  logic               neg;
  logic [41:0]        abs_sum;
  logic [33:0]        mag;
  logic [6:0]         lim;
  logic [6:0]         pmag;
  logic [6:0]         mmag;

  // Error in either mode
  assign err_drive = $signed({tgt_q[20], tgt_q}) - $signed({enc_q[20], enc_q});
  assign err_turn  = $signed({{6{ang_q[15]}}, ang_q})
                   - $signed({{6{start_angle[15]}}, start_angle})
                   - $signed({tgt_q[20], tgt_q});

  assign err_wide = $signed({err_q[21], err_q});
  assign err_diff = err_wide - $signed({prev_err[21], prev_err});

  // Select multiplier operands
  always_comb begin
    case (ctrl.mul)
      wpdr_pkg::MUL_D: begin
        mul_a = err_diff;
        mul_b = $signed({1'b0, cfg.gain_d});
      end
      wpdr_pkg::MUL_I: begin
        mul_a = err_wide;
        mul_b = $signed({1'b0, cfg.gain_i});
      end
      default: begin
        mul_a = err_wide;
        mul_b = $signed({1'b0, cfg.gain_p});
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // Integral update with window and saturation
  assign int_sum = $signed({{9{integral[31]}}, integral}) + $signed({prod[39], prod});
  always_comb begin
    if (int_sum[40:31] == {10{int_sum[40]}}) begin
      int_sat = int_sum[31:0];
    end else if (int_sum[40]) begin
      int_sat = {1'b1, 31'b0};
    end else begin
      int_sat = {1'b0, {31{1'b1}}};
    end
  end

  assign win_lim   = $signed({7'b0, cfg.integral_window});
  assign in_window = (err_wide < win_lim) && ((-err_wide) < win_lim);

  // Truncate toward zero and clamp
  assign neg     = acc[41];
  assign abs_sum = neg ? 42'(-acc) : 42'(acc);
  assign mag     = abs_sum[41:8];

  always_comb begin
    lim = cfg.output_limit;
    if ((tick < cfg.startup_ticks) && (cfg.startup_limit < lim)) begin
      lim = cfg.startup_limit;
    end
    pmag = (mag > {27'b0, lim}) ? lim : mag[6:0];
    mmag = wpdr_pkg::motor_scale(pmag);
  end

  assign result.drive_power   = neg ? $signed(-{1'b0, pmag}) : $signed({1'b0, pmag});
  assign result.motor_command = neg ? $signed(-{1'b0, mmag}) : $signed({1'b0, mmag});
  assign result.error_value   = err_q;

  // Latch the input word, the error, the product and the accumulator
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      tgt_q <= target;
      enc_q <= encoder_count;
      ang_q <= gyro_angle;
    end
    if (ctrl.latch_err) begin
      err_q <= cfg.turn_mode ? err_turn : err_drive;
    end
    if (ctrl.mul != wpdr_pkg::MUL_NONE) begin
      prod <= mul_out;
    end
    case (ctrl.acc)
      wpdr_pkg::ACC_LOAD:     acc <= 42'(prod);
      wpdr_pkg::ACC_ADD_PROD: acc <= acc + 42'(prod);
      wpdr_pkg::ACC_ADD_INT:  acc <= acc + 42'(integral);
      default:                acc <= acc;
    endcase
  end

  // Hold controller state across ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      integral    <= '0;
      prev_err    <= '0;
      tick        <= '0;
      start_angle <= '0;
    end else begin
      if (ctrl.load_in && restart) begin
        integral    <= '0;
        prev_err    <= '0;
        tick        <= '0;
        start_angle <= gyro_angle;
      end
      if (ctrl.upd_int) begin
        integral <= in_window ? int_sat : '0;
        prev_err <= err_q;
      end
      if (ctrl.emit && (tick != wpdr_pkg::TICK_MAX)) begin
        tick <= tick + 3'd1;
      end
    end
  end

endmodule

[src/windowed_pid_drive_regulator.sv]
// ----------------------------------------------------------------------------
// windowed_pid_drive_regulator
// PID drive regulator with integral window, output clamp and startup clamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one control tick word: restart,
//   target, encoder_count and gyro_angle. Output channel (out_valid/out_stall)
//   returns one word per tick: drive_power, motor_command and error_value.
//   Registers are written over cfg_write/cfg_index/cfg_data while idle.
// Sequence:
//   Once a word is accepted, a microcoded program latches the error and steps
//   one shared 23x17 multiplier through the P, D and I products and one
//   accumulator, then updates and adds the integral. The next word is accepted
//   in the cycle after the result loads, so words do not overlap.
// Reset:
//   rst (synchronous) restores register defaults, clears the integral, the
//   previous error, the tick count and the start angle, and empties the
//   output register.
// Stall:
//   The result waits in the output register; the program holds at its last
//   step until the register frees, and in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
module windowed_pid_drive_regulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               restart,
  input  logic signed [20:0] target,
  input  logic signed [20:0] encoder_count,
  input  logic signed [15:0] gyro_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  drive_power,
  output logic signed [7:0]  motor_command,
  output logic signed [21:0] error_value
);

  wpdr_pkg::cfg_t        cfg;
  wpdr_pkg::ctrl_word_t  ctrl;
  wpdr_pkg::seq_status_t status;
  wpdr_pkg::result_t     result;
  logic                  ready;

  assign status.in_valid = in_valid;
  assign status.out_busy = out_valid && out_stall;
  assign in_stall        = !ready;

  wpdr_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .ready  (ready)
  );

  wpdr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cfg           (cfg),
    .restart       (restart),
    .target        (target),
    .encoder_count (encoder_count),
    .gyro_angle    (gyro_angle),
    .result        (result)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p          <= wpdr_pkg::GAIN_P_RST;
      cfg.gain_i          <= wpdr_pkg::GAIN_I_RST;
      cfg.gain_d          <= wpdr_pkg::GAIN_D_RST;
      cfg.integral_window <= wpdr_pkg::WINDOW_RST;
      cfg.output_limit    <= wpdr_pkg::OUTPUT_LIMIT_RST;
      cfg.startup_limit   <= wpdr_pkg::STARTUP_LIMIT_RST;
      cfg.startup_ticks   <= wpdr_pkg::STARTUP_TICKS_RST;
      cfg.turn_mode       <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wpdr_pkg::REG_GAIN_P:        cfg.gain_p          <= cfg_data;
        wpdr_pkg::REG_GAIN_I:        cfg.gain_i          <= cfg_data;
        wpdr_pkg::REG_GAIN_D:        cfg.gain_d          <= cfg_data;
        wpdr_pkg::REG_WINDOW:        cfg.integral_window <= cfg_data;
        wpdr_pkg::REG_OUTPUT_LIMIT:  cfg.output_limit    <= cfg_data[6:0];
        wpdr_pkg::REG_STARTUP_LIMIT: cfg.startup_limit   <= cfg_data[6:0];
        wpdr_pkg::REG_STARTUP_TICKS: cfg.startup_ticks   <= cfg_data[2:0];
        wpdr_pkg::REG_TURN_MODE:     cfg.turn_mode       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      drive_power   <= result.drive_power;
      motor_command <= result.motor_command;
      error_value   <= result.error_value;
    end
  end

endmodule
